@@ hdl/sdoc_pkg.sv @@
package sdoc_pkg;

   // input item operations
   typedef logic [1:0] op_type;
   localparam op_type OP_READ  = 2'd0;
   localparam op_type OP_WRITE = 2'd1;
   localparam op_type OP_FRAME = 2'd2;
   localparam op_type OP_TICK  = 2'd3;

   // result item kinds
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_TX    = 2'd0;
   localparam kind_type KIND_DONE  = 2'd1;
   localparam kind_type KIND_ABORT = 2'd2;
   localparam kind_type KIND_FAIL  = 2'd3;

   // transfer size codes
   typedef logic [1:0] size_type;
   localparam size_type SIZE_1B  = 2'd0;
   localparam size_type SIZE_2B  = 2'd1;
   localparam size_type SIZE_4B  = 2'd2;
   localparam size_type SIZE_BAD = 2'd3;

   // sdo command bytes and cob-id bases
   localparam logic [7:0]  CMD_UPLOAD_REQ = 8'h40;
   localparam logic [7:0]  CMD_UPLOAD_1B  = 8'h4F;
   localparam logic [7:0]  CMD_UPLOAD_2B  = 8'h4B;
   localparam logic [7:0]  CMD_UPLOAD_4B  = 8'h43;
   localparam logic [7:0]  CMD_ABORT      = 8'h80;
   localparam logic [7:0]  CMD_DOWNLOAD_1B = 8'h2F;
   localparam logic [7:0]  CMD_DOWNLOAD_2B = 8'h2B;
   localparam logic [7:0]  CMD_DOWNLOAD_4B = 8'h23;
   localparam logic [10:0] COB_RX_SDO     = 11'h600;
   localparam logic [10:0] COB_TX_SDO     = 11'h580;

   // register map
   localparam int CSR_ADDR_W = 4;
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_NODE_ID = 2'd0;
   localparam csr_index_type CSR_TIMEOUT = 2'd1;
   localparam csr_index_type CSR_RETRY   = 2'd2;

   localparam logic [6:0]  NODE_ID_RESET = 7'd1;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [3:0]  RETRY_RESET   = 4'd3;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // classified item; for frames index/subindex/cmd/value come from the frame bytes
   typedef struct packed {
      op_type      op;
      logic [15:0] index;
      logic [7:0]  subindex;
      size_type    size;
      logic [31:0] value;
      logic [7:0]  cmd;
      logic        id_match;
   } item_type;

   typedef struct packed {
      kind_type    kind;
      logic [10:0] tx_id;
      logic [63:0] tx_bytes;
      logic [31:0] read_value;
      logic [31:0] abort_code;
   } result_type;

   function automatic logic [63:0] addr_bytes(input logic [7:0] cmd,
                                              input logic [15:0] idx,
                                              input logic [7:0] sub);
      addr_bytes = {32'h0, sub, idx, cmd};
   endfunction

endpackage

@@ hdl/sdoc_front.sv @@
module sdoc_front (
   input  sdoc_pkg::op_type    req_op,
   input  logic [15:0]         req_object_index,
   input  logic [7:0]          req_object_subindex,
   input  sdoc_pkg::size_type  req_data_size,
   input  logic [31:0]         req_write_value,
   input  logic [28:0]         req_frame_id,
   input  logic [63:0]         req_frame_bytes,
   input  logic [6:0]          node_id,
   output sdoc_pkg::item_type  item
);

   logic [10:0] reply_id;

   assign reply_id = sdoc_pkg::COB_TX_SDO + {4'h0, node_id};

   always_comb begin
      item.op       = req_op;
      item.size     = req_data_size;
      item.id_match = (req_frame_id == {18'h0, reply_id});
      if (req_op == sdoc_pkg::OP_FRAME) begin
         // unpack the reply: command, index, subindex, data word
         item.cmd      = req_frame_bytes[7:0];
         item.index    = req_frame_bytes[23:8];
         item.subindex = req_frame_bytes[31:24];
         item.value    = req_frame_bytes[63:32];
      end else begin
         item.cmd      = 8'h00;
         item.index    = req_object_index;
         item.subindex = req_object_subindex;
         item.value    = req_write_value;
      end
   end

endmodule

@@ hdl/sdoc_queue.sv @@
module sdoc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sdoc_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               q_valid,
   output sdoc_pkg::item_type q_item
);

   localparam int CNT_W = $clog2(sdoc_pkg::QUEUE_DEPTH + 1);

   sdoc_pkg::item_type               mem_ff [sdoc_pkg::QUEUE_DEPTH];
   logic [sdoc_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [sdoc_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]                 count_ff, count_in;

   assign full    = (count_ff == CNT_W'(sdoc_pkg::QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hdl/sdoc_back.sv @@
module sdoc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  sdoc_pkg::item_type   q_item,
   output logic                 pop,
   input  logic [6:0]           node_id,
   input  logic [15:0]          timeout_ticks,
   input  logic [3:0]           retry_limit,
   output logic                 out_valid,
   input  logic                 out_ready,
   output sdoc_pkg::result_type out_result
);

   logic                 pending_ff, pending_in;
   logic [15:0]          pidx_ff, pidx_in;
   logic [7:0]           psub_ff, psub_in;
   sdoc_pkg::size_type   psize_ff, psize_in;
   logic [3:0]           attempts_ff, attempts_in;
   logic [15:0]          timer_ff, timer_in;
   logic                 out_valid_ff, out_valid_in;
   sdoc_pkg::result_type out_ff, out_in;

   sdoc_pkg::result_type res;
   logic                 has_res;
   logic                 fail_try;
   logic                 cmd_ok;
   logic [16:0]          timer_nx;
   logic [10:0]          tx_base;
   logic [63:0]          wbytes;
   logic                 fire;

   assign fire     = q_valid && (!out_valid_ff || out_ready);
   assign pop      = fire;
   assign tx_base  = sdoc_pkg::COB_RX_SDO + {4'h0, node_id};
   assign timer_nx = {1'b0, timer_ff} + 17'd1;

   // reply command accepted for the pending size
   always_comb begin
      case (psize_ff)
         sdoc_pkg::SIZE_1B: cmd_ok = (q_item.cmd == sdoc_pkg::CMD_UPLOAD_1B);
         sdoc_pkg::SIZE_2B: cmd_ok = (q_item.cmd == sdoc_pkg::CMD_UPLOAD_2B) ||
                                     (q_item.cmd == sdoc_pkg::CMD_UPLOAD_1B);
         default:           cmd_ok = (q_item.cmd == sdoc_pkg::CMD_UPLOAD_4B) ||
                                     (q_item.cmd == sdoc_pkg::CMD_UPLOAD_1B);
      endcase
   end

   always_comb begin
      pending_in  = pending_ff;
      pidx_in     = pidx_ff;
      psub_in     = psub_ff;
      psize_in    = psize_ff;
      attempts_in = attempts_ff;
      timer_in    = timer_ff;
      res         = '0;
      has_res     = 1'b0;
      fail_try    = 1'b0;
      wbytes      = '0;

      case (q_item.op)
         sdoc_pkg::OP_READ: begin
            if (!pending_ff) begin
               has_res = 1'b1;
               if (q_item.size == sdoc_pkg::SIZE_BAD || retry_limit == 4'd0) begin
                  res.kind = sdoc_pkg::KIND_FAIL;
               end else begin
                  pending_in   = 1'b1;
                  pidx_in      = q_item.index;
                  psub_in      = q_item.subindex;
                  psize_in     = q_item.size;
                  attempts_in  = 4'd1;
                  timer_in     = 16'd0;
                  res.kind     = sdoc_pkg::KIND_TX;
                  res.tx_id    = tx_base;
                  res.tx_bytes = sdoc_pkg::addr_bytes(sdoc_pkg::CMD_UPLOAD_REQ,
                                                      q_item.index, q_item.subindex);
               end
            end
         end
         sdoc_pkg::OP_WRITE: begin
            case (q_item.size)
               sdoc_pkg::SIZE_1B: begin
                  has_res = 1'b1;
                  wbytes  = sdoc_pkg::addr_bytes(sdoc_pkg::CMD_DOWNLOAD_1B,
                                                 q_item.index, q_item.subindex) |
                            {24'h0, q_item.value[7:0], 32'h0};
               end
               sdoc_pkg::SIZE_2B: begin
                  has_res = 1'b1;
                  wbytes  = sdoc_pkg::addr_bytes(sdoc_pkg::CMD_DOWNLOAD_2B,
                                                 q_item.index, q_item.subindex) |
                            {16'h0, q_item.value[15:0], 32'h0};
               end
               sdoc_pkg::SIZE_4B: begin
                  has_res = 1'b1;
                  wbytes  = sdoc_pkg::addr_bytes(sdoc_pkg::CMD_DOWNLOAD_4B,
                                                 q_item.index, q_item.subindex) |
                            {q_item.value, 32'h0};
               end
               default: ;
            endcase
            if (has_res) begin
               res.kind     = sdoc_pkg::KIND_TX;
               res.tx_id    = tx_base;
               res.tx_bytes = wbytes;
            end
         end
         sdoc_pkg::OP_FRAME: begin
            if (pending_ff && q_item.id_match) begin
               if (q_item.cmd == sdoc_pkg::CMD_ABORT) begin
                  pending_in     = 1'b0;
                  has_res        = 1'b1;
                  res.kind       = sdoc_pkg::KIND_ABORT;
                  res.abort_code = q_item.value;
               end else if (cmd_ok && q_item.index == pidx_ff &&
                            q_item.subindex == psub_ff) begin
                  pending_in = 1'b0;
                  has_res    = 1'b1;
                  res.kind   = sdoc_pkg::KIND_DONE;
                  case (psize_ff)
                     sdoc_pkg::SIZE_1B: res.read_value = {24'h0, q_item.value[7:0]};
                     sdoc_pkg::SIZE_2B: res.read_value = {16'h0, q_item.value[15:0]};
                     default:           res.read_value = q_item.value;
                  endcase
               end else begin
                  fail_try = 1'b1;
               end
            end
         end
         sdoc_pkg::OP_TICK: begin
            if (pending_ff) begin
               timer_in = timer_nx[15:0];
               // wrap to zero also counts as expiry
               if (timer_nx[16] || timer_nx[15:0] >= timeout_ticks) begin
                  fail_try = 1'b1;
               end
            end
         end
         default: ;
      endcase

      if (fail_try) begin
         has_res = 1'b1;
         if (attempts_ff < retry_limit) begin
            attempts_in  = attempts_ff + 4'd1;
            timer_in     = 16'd0;
            res.kind     = sdoc_pkg::KIND_TX;
            res.tx_id    = tx_base;
            res.tx_bytes = sdoc_pkg::addr_bytes(sdoc_pkg::CMD_UPLOAD_REQ, pidx_ff, psub_ff);
         end else begin
            pending_in = 1'b0;
            res        = '0;
            res.kind   = sdoc_pkg::KIND_FAIL;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_valid_ff && out_ready) begin
         out_valid_in = 1'b0;
      end
      if (fire && has_res) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         pidx_ff      <= '0;
         psub_ff      <= '0;
         psize_ff     <= sdoc_pkg::SIZE_1B;
         attempts_ff  <= '0;
         timer_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            pending_ff  <= pending_in;
            pidx_ff     <= pidx_in;
            psub_ff     <= psub_in;
            psize_ff    <= psize_in;
            attempts_ff <= attempts_in;
            timer_ff    <= timer_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

endmodule

@@ hdl/sdo_expedited_client.sv @@
// expedited sdo client for one canopen server node
//
// input channel (req_*): one item per handshake; op selects read request,
//   write request, received frame or time tick. frames on other ids and
//   ticks while no read is open produce no result item
// result channel (rsp_*): at most one item per input item, in order:
//   transmit frame, read done, read aborted or read failed (at once or after retries)
// configuration: apb-style port, node_id at 0x0, timeout_ticks at 0x4,
//   retry_limit at 0x8; pready is tied high, writes land on the access cycle
// throughput: one item per cycle sustained while the output register is free or
//   being taken; the protocol state in the back end updates once per item
// path: with the back end free, an accepted input item is written into the
//   queue, and the back end then executes it from the queue into the output
//   register, where its result item becomes valid
// reset: synchronous; clears the open read, queue and output register and
//   loads node_id 1, timeout_ticks 1000, retry_limit 3
// stall: a result item waits in the output register and the back end holds
//   every item until that slot frees; later items wait in the 2-entry queue
//   and req_ready drops once it fills
module sdo_expedited_client (
   input  logic        clock,
   input  logic        reset,

   // input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [15:0] req_object_index,
   input  logic [7:0]  req_object_subindex,
   input  logic [1:0]  req_data_size,
   input  logic [31:0] req_write_value,
   input  logic [28:0] req_frame_id,
   input  logic [63:0] req_frame_bytes,

   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [10:0] rsp_tx_id,
   output logic [63:0] rsp_tx_bytes,
   output logic [31:0] rsp_read_value,
   output logic [31:0] rsp_abort_code,

   // configuration port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [sdoc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   // configuration registers
   logic [6:0]  node_id_ff;
   logic [15:0] timeout_ff;
   logic [3:0]  retry_ff;
   logic        csr_wr;
   sdoc_pkg::csr_index_type csr_idx;

   sdoc_pkg::item_type   front_item;
   sdoc_pkg::item_type   q_item;
   sdoc_pkg::result_type result;
   logic                 q_full;
   logic                 q_valid;
   logic                 q_pop;
   logic                 push;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[sdoc_pkg::CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff <= sdoc_pkg::NODE_ID_RESET;
         timeout_ff <= sdoc_pkg::TIMEOUT_RESET;
         retry_ff   <= sdoc_pkg::RETRY_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            sdoc_pkg::CSR_NODE_ID: node_id_ff <= pwdata[6:0];
            sdoc_pkg::CSR_TIMEOUT: timeout_ff <= pwdata[15:0];
            sdoc_pkg::CSR_RETRY:   retry_ff   <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_idx)
         sdoc_pkg::CSR_NODE_ID: prdata = {25'h0, node_id_ff};
         sdoc_pkg::CSR_TIMEOUT: prdata = {16'h0, timeout_ff};
         sdoc_pkg::CSR_RETRY:   prdata = {28'h0, retry_ff};
         default:               prdata = 32'h0;
      endcase
   end

   // front: classify and unpack the incoming item
   sdoc_front u_front (
      .req_op              (req_op),
      .req_object_index    (req_object_index),
      .req_object_subindex (req_object_subindex),
      .req_data_size       (req_data_size),
      .req_write_value     (req_write_value),
      .req_frame_id        (req_frame_id),
      .req_frame_bytes     (req_frame_bytes),
      .node_id             (node_id_ff),
      .item                (front_item)
   );

   // ready only depends on queue fill, never on the result side
   assign req_ready = !q_full;
   assign push      = req_valid && req_ready;

   sdoc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .q_valid   (q_valid),
      .q_item    (q_item)
   );

   // back: protocol state, retries, timeout and result register
   sdoc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .pop           (q_pop),
      .node_id       (node_id_ff),
      .timeout_ticks (timeout_ff),
      .retry_limit   (retry_ff),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_result    (result)
   );

   assign rsp_result_kind = result.kind;
   assign rsp_tx_id       = result.tx_id;
   assign rsp_tx_bytes    = result.tx_bytes;
   assign rsp_read_value  = result.read_value;
   assign rsp_abort_code  = result.abort_code;

endmodule

@@ hdl/sdoc_checker.sv @@
module sdoc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [1:0]                      rsp_result_kind,
   input logic [10:0]                     rsp_tx_id,
   input logic [63:0]                     rsp_tx_bytes,
   input logic [31:0]                     rsp_read_value,
   input logic [31:0]                     rsp_abort_code,
   input logic                            psel,
   input logic                            penable,
   input logic                            pwrite,
   input logic [sdoc_pkg::CSR_ADDR_W-1:0] paddr,
   input logic [31:0]                     pwdata,
   input logic [31:0]                     prdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_bytes) &&
                                  $stable(rsp_result_kind))
      else $error("result changed while stalled");

   // reset empties the output register
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // non-transmit results carry no frame
   a_no_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != sdoc_pkg::KIND_TX |->
         rsp_tx_id == 11'h0 && rsp_tx_bytes == 64'h0)
      else $error("frame fields set on non-transmit result");

   // value and abort code only on their own kinds
   a_value_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_kind == sdoc_pkg::KIND_DONE || rsp_read_value == 32'h0) &&
                    (rsp_result_kind == sdoc_pkg::KIND_ABORT || rsp_abort_code == 32'h0))
      else $error("payload field set on wrong result kind");

   // node id readback follows a write
   a_node_id_rb: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite &&
      paddr[sdoc_pkg::CSR_ADDR_W-1:2] == sdoc_pkg::CSR_NODE_ID |=>
         paddr[sdoc_pkg::CSR_ADDR_W-1:2] != sdoc_pkg::CSR_NODE_ID ||
         prdata[6:0] == $past(pwdata[6:0]))
      else $error("node id readback mismatch");

endmodule

bind sdo_expedited_client sdoc_checker u_sdoc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_result_kind (rsp_result_kind),
   .rsp_tx_id       (rsp_tx_id),
   .rsp_tx_bytes    (rsp_tx_bytes),
   .rsp_read_value  (rsp_read_value),
   .rsp_abort_code  (rsp_abort_code),
   .psel            (psel),
   .penable         (penable),
   .pwrite          (pwrite),
   .paddr           (paddr),
   .pwdata          (pwdata),
   .prdata          (prdata)
);

@@ test/sdo_client_checker.sv @@
module sdo_client_checker
   import sdoc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [15:0]           req_object_index,
   input  logic [7:0]            req_object_subindex,
   input  logic [1:0]            req_data_size,
   input  logic [31:0]           req_write_value,
   input  logic [28:0]           req_frame_id,
   input  logic [63:0]           req_frame_bytes,

   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [1:0]            rsp_result_kind,
   input  logic [10:0]           rsp_tx_id,
   input  logic [63:0]           rsp_tx_bytes,
   input  logic [31:0]           rsp_read_value,
   input  logic [31:0]           rsp_abort_code,

   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,

   output int                    mismatches,
   output int                    awaited
);

   // shadow of the client registers and of the open read
   logic [6:0]  node_id;
   logic [15:0] timeout_ticks;
   logic [3:0]  retry_limit;
   logic        read_open;
   logic [15:0] open_index;
   logic [7:0]  open_subindex;
   size_type    open_size;
   logic [3:0]  attempts;
   logic [15:0] ticks_waited;

   // outcomes predicted but not yet seen on the result channel
   result_type  outcome_q [$];

   function automatic result_type upload_frame();
      result_type r;
      r = '0;
      r.kind     = KIND_TX;
      r.tx_id    = COB_RX_SDO + 11'(node_id);
      r.tx_bytes = {32'h0, open_subindex, open_index, CMD_UPLOAD_REQ};
      return r;
   endfunction

   // one attempt lost: send again while attempts remain, else give up
   function automatic result_type attempt_failed();
      result_type r;
      if (attempts < retry_limit) begin
         attempts     = attempts + 4'd1;
         ticks_waited = '0;
         r = upload_frame();
      end else begin
         read_open = 1'b0;
         r = '0;
         r.kind = KIND_FAIL;
      end
      return r;
   endfunction

   function automatic bit client_step(input op_type op, input logic [15:0] idx,
                                      input logic [7:0] sub, input size_type size,
                                      input logic [31:0] wval, input logic [28:0] fid,
                                      input logic [63:0] fb, output result_type r);
      logic [31:0] val;
      logic [7:0]  cmd;
      bit          ok;
      r = '0;
      case (op)
         OP_READ: begin
            if (read_open) return 1'b0;
            if (size == SIZE_BAD || retry_limit == 4'd0) begin
               r.kind = KIND_FAIL;
               return 1'b1;
            end
            read_open     = 1'b1;
            open_index    = idx;
            open_subindex = sub;
            open_size     = size;
            attempts      = 4'd1;
            ticks_waited  = '0;
            r = upload_frame();
            return 1'b1;
         end
         OP_WRITE: begin
            case (size)
               SIZE_1B: begin
                  cmd = CMD_DOWNLOAD_1B;
                  val = {24'h0, wval[7:0]};
               end
               SIZE_2B: begin
                  cmd = CMD_DOWNLOAD_2B;
                  val = {16'h0, wval[15:0]};
               end
               SIZE_4B: begin
                  cmd = CMD_DOWNLOAD_4B;
                  val = wval;
               end
               default: return 1'b0;
            endcase
            r.kind     = KIND_TX;
            r.tx_id    = COB_RX_SDO + 11'(node_id);
            r.tx_bytes = {val, sub, idx, cmd};
            return 1'b1;
         end
         OP_FRAME: begin
            if (!read_open || fid != 29'(COB_TX_SDO) + 29'(node_id)) return 1'b0;
            cmd = fb[7:0];
            if (cmd == CMD_ABORT) begin
               read_open    = 1'b0;
               r.kind       = KIND_ABORT;
               r.abort_code = fb[63:32];
               return 1'b1;
            end
            case (open_size)
               SIZE_1B: begin
                  ok  = (cmd == CMD_UPLOAD_1B);
                  val = {24'h0, fb[39:32]};
               end
               SIZE_2B: begin
                  ok  = (cmd == CMD_UPLOAD_2B || cmd == CMD_UPLOAD_1B);
                  val = {16'h0, fb[47:32]};
               end
               default: begin
                  ok  = (cmd == CMD_UPLOAD_4B || cmd == CMD_UPLOAD_1B);
                  val = fb[63:32];
               end
            endcase
            if (ok && fb[23:8] == open_index && fb[31:24] == open_subindex) begin
               read_open    = 1'b0;
               r.kind       = KIND_DONE;
               r.read_value = val;
               return 1'b1;
            end
            r = attempt_failed();
            return 1'b1;
         end
         default: begin
            if (!read_open) return 1'b0;
            ticks_waited = ticks_waited + 16'd1;
            // a zero timeout behaves like one
            if (ticks_waited >= timeout_ticks || ticks_waited == 16'd0) begin
               r = attempt_failed();
               return 1'b1;
            end
            return 1'b0;
         end
      endcase
   endfunction

   always @(posedge clock) begin : monitor
      result_type got;
      result_type want;
      result_type pred;
      if (reset) begin
         node_id       = NODE_ID_RESET;
         timeout_ticks = TIMEOUT_RESET;
         retry_limit   = RETRY_RESET;
         read_open     = 1'b0;
         open_index    = '0;
         open_subindex = '0;
         open_size     = SIZE_1B;
         attempts      = '0;
         ticks_waited  = '0;
         outcome_q.delete();
         mismatches    = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (csr_index_type'(paddr[CSR_ADDR_W-1:2]))
               CSR_NODE_ID: node_id       = pwdata[6:0];
               CSR_TIMEOUT: timeout_ticks = pwdata[15:0];
               CSR_RETRY:   retry_limit   = pwdata[3:0];
               default: ;
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            got.kind       = rsp_result_kind;
            got.tx_id      = rsp_tx_id;
            got.tx_bytes   = rsp_tx_bytes;
            got.read_value = rsp_read_value;
            got.abort_code = rsp_abort_code;
            if (outcome_q.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected result item kind %0d id %h bytes %h value %h abort %h",
                           $realtime, got.kind, got.tx_id, got.tx_bytes, got.read_value,
                           got.abort_code);
               mismatches++;
            end else begin
               want = outcome_q.pop_front();
               if (got.kind !== want.kind || got.tx_id !== want.tx_id ||
                   got.tx_bytes !== want.tx_bytes || got.read_value !== want.read_value ||
                   got.abort_code !== want.abort_code) begin
                  if (mismatches < 10) begin
                     $display("%0t: result item mismatch (expected / actual)", $realtime);
                     $display("   kind  %0d / %0d", want.kind, got.kind);
                     $display("   id    %h / %h", want.tx_id, got.tx_id);
                     $display("   bytes %h / %h", want.tx_bytes, got.tx_bytes);
                     $display("   value %h / %h", want.read_value, got.read_value);
                     $display("   abort %h / %h", want.abort_code, got.abort_code);
                  end
                  mismatches++;
               end
            end
         end

         if (req_valid && req_ready) begin
            if (client_step(op_type'(req_op), req_object_index, req_object_subindex,
                            size_type'(req_data_size), req_write_value, req_frame_id,
                            req_frame_bytes, pred))
               outcome_q.push_back(pred);
         end
      end
      awaited <= outcome_q.size();
   end

endmodule

@@ test/tb.sv @@
module tb;
   import sdoc_pkg::*;

   // clock and the single reset at start of run
   logic        clock = 1'b0;
   logic        reset = 1'b1;

   // input channel, all driven to known values from time zero
   logic        req_valid           = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op              = '0;
   logic [15:0] req_object_index    = '0;
   logic [7:0]  req_object_subindex = '0;
   logic [1:0]  req_data_size       = '0;
   logic [31:0] req_write_value     = '0;
   logic [28:0] req_frame_id        = '0;
   logic [63:0] req_frame_bytes     = '0;

   // result channel
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [10:0] rsp_tx_id;
   logic [63:0] rsp_tx_bytes;
   logic [31:0] rsp_read_value;
   logic [31:0] rsp_abort_code;

   // apb-style register port
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [31:0]           pwdata  = '0;
   logic [31:0]           prdata;
   logic                  pready;

   int mismatches;
   int awaited;

   // what the stimulus believes is programmed, used to build replies
   logic [6:0]  cfg_node    = NODE_ID_RESET;
   logic [15:0] cfg_timeout = TIMEOUT_RESET;
   logic [3:0]  cfg_retry   = RETRY_RESET;

   bit sender_steady = 1'b0;   // phase with no gaps on the input side
   bit hold_armed    = 1'b0;   // asks the result side for one long hold-off
   int items_sent    = 0;

   always #5 clock = ~clock;

   sdo_expedited_client u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_object_index    (req_object_index),
      .req_object_subindex (req_object_subindex),
      .req_data_size       (req_data_size),
      .req_write_value     (req_write_value),
      .req_frame_id        (req_frame_id),
      .req_frame_bytes     (req_frame_bytes),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_tx_id           (rsp_tx_id),
      .rsp_tx_bytes        (rsp_tx_bytes),
      .rsp_read_value      (rsp_read_value),
      .rsp_abort_code      (rsp_abort_code),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   // watches both channels and the register port, predicts and compares
   sdo_client_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_object_index    (req_object_index),
      .req_object_subindex (req_object_subindex),
      .req_data_size       (req_data_size),
      .req_write_value     (req_write_value),
      .req_frame_id        (req_frame_id),
      .req_frame_bytes     (req_frame_bytes),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_tx_id           (rsp_tx_id),
      .rsp_tx_bytes        (rsp_tx_bytes),
      .rsp_read_value      (rsp_read_value),
      .rsp_abort_code      (rsp_abort_code),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .pready              (pready),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .mismatches          (mismatches),
      .awaited             (awaited)
   );

   // idle length: mostly none, often short, now and then a long one
   function automatic int unsigned random_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // id on which the server answers
   function automatic logic [28:0] server_reply_id();
      return 29'(COB_TX_SDO) + 29'(cfg_node);
   endfunction

   // any accepted upload command for the size; 0x4f fits every size
   function automatic logic [7:0] good_cmd(input size_type size);
      case (size)
         SIZE_2B: good_cmd = $urandom_range(0, 1) ? CMD_UPLOAD_2B : CMD_UPLOAD_1B;
         SIZE_4B: good_cmd = $urandom_range(0, 1) ? CMD_UPLOAD_4B : CMD_UPLOAD_1B;
         default: good_cmd = CMD_UPLOAD_1B;
      endcase
   endfunction

   // present one item and hold it until accepted; valid is left high on
   // return so that a following item with no gap keeps it up
   task automatic offer(input op_type op, input logic [15:0] idx, input logic [7:0] sub,
                        input size_type size, input logic [31:0] wval,
                        input logic [28:0] fid, input logic [63:0] fb);
      int unsigned gap;
      gap = sender_steady ? 0 : random_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_op              <= op;
      req_object_index    <= idx;
      req_object_subindex <= sub;
      req_data_size       <= size;
      req_write_value     <= wval;
      req_frame_id        <= fid;
      req_frame_bytes     <= fb;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // fields that the op does not use carry random junk
   task automatic send_read(input logic [15:0] idx, input logic [7:0] sub,
                            input size_type size);
      offer(OP_READ, idx, sub, size, $urandom, 29'($urandom), {$urandom, $urandom});
   endtask

   task automatic send_write(input logic [15:0] idx, input logic [7:0] sub,
                             input size_type size, input logic [31:0] wval);
      offer(OP_WRITE, idx, sub, size, wval, 29'($urandom), {$urandom, $urandom});
   endtask

   task automatic send_frame(input logic [28:0] fid, input logic [63:0] fb);
      offer(OP_FRAME, 16'($urandom), 8'($urandom), size_type'($urandom), $urandom, fid, fb);
   endtask

   task automatic send_reply(input logic [7:0] cmd, input logic [15:0] idx,
                             input logic [7:0] sub, input logic [31:0] hi);
      send_frame(server_reply_id(), {hi, sub, idx, cmd});
   endtask

   task automatic send_tick();
      offer(OP_TICK, 16'($urandom), 8'($urandom), size_type'($urandom), $urandom,
            29'($urandom), {$urandom, $urandom});
   endtask

   // drop valid, wait for every outstanding item, then let the pipeline
   // finish items that produce nothing
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // setup cycle then access cycle; register lands on the access edge
   task automatic csr_write(input csr_index_type reg_index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [6:0] node, input logic [15:0] tmo,
                            input logic [3:0] retry);
      drain();
      csr_write(CSR_NODE_ID, 32'(node));
      csr_write(CSR_TIMEOUT, 32'(tmo));
      csr_write(CSR_RETRY, 32'(retry));
      cfg_node    = node;
      cfg_timeout = tmo;
      cfg_retry   = retry;
   endtask

   // items that sit between a request and its reply
   task automatic filler();
      case ($urandom_range(0, 2))
         0: send_tick();
         1: send_frame(29'($urandom), {$urandom, $urandom});
         default: send_write(16'($urandom), 8'($urandom),
                             size_type'($urandom_range(0, 2)), $urandom);
      endcase
   endtask

   // anything at all, half the frames aimed at the server reply id
   task automatic noise_item();
      op_type op;
      op = op_type'($urandom_range(0, 3));
      if (op == OP_FRAME && $urandom_range(0, 1) != 0)
         send_frame(server_reply_id(), {$urandom, $urandom});
      else
         offer(op, 16'($urandom), 8'($urandom), size_type'($urandom), $urandom,
               29'($urandom), {$urandom, $urandom});
   endtask

   // a read request followed by its answer; now and then the answer is an
   // abort, comes after a bad reply or a timeout, or never comes
   task automatic read_sequence();
      logic [15:0] idx;
      logic [7:0]  sub;
      size_type    size;
      int unsigned pick;
      idx  = 16'($urandom);
      sub  = 8'($urandom);
      size = ($urandom_range(0, 19) == 0) ? SIZE_BAD : size_type'($urandom_range(0, 2));
      send_read(idx, sub, size);
      repeat ($urandom_range(0, 2)) filler();
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         send_reply(CMD_ABORT, 16'($urandom), 8'($urandom), $urandom);
      end else if (pick < 95) begin
         if (pick < 15)
            send_reply(8'($urandom), idx, sub, $urandom);
         else if (pick < 20)
            send_reply(good_cmd(size), idx ^ 16'($urandom_range(1, 65535)), sub, $urandom);
         else if (pick < 30)
            repeat ((cfg_timeout <= 16) ? cfg_timeout : 16'd3) send_tick();
         send_reply(good_cmd(size), idx, sub, $urandom);
      end
   endtask

   initial begin : stimulus
      int phase;
      int goal;
      int unsigned pick;
      int waited;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part: small timeout and retry count so every path is short
      configure(7'd5, 16'd3, 4'd2);
      send_tick();                                          // tick with no read open
      send_reply(CMD_UPLOAD_1B, 16'h1234, 8'h01, 32'h5);    // reply with no read open
      send_write(16'h0000, 8'h00, SIZE_1B, 32'h0000_0000);
      send_write(16'hFFFF, 8'hFF, SIZE_2B, 32'hFFFF_FFFF);
      send_write(16'h5A5A, 8'hA5, SIZE_4B, 32'hDEAD_BEEF);
      send_write(16'h2000, 8'h03, SIZE_BAD, 32'h1234_5678); // bad size write ignored
      send_read(16'h3000, 8'h02, SIZE_BAD);                 // bad size read fails at once
      send_read(16'h1234, 8'h01, SIZE_1B);
      send_read(16'h4321, 8'h10, SIZE_2B);                  // read while one is open, dropped
      send_frame(server_reply_id() + 29'd1, {32'h11, 8'h01, 16'h1234, CMD_UPLOAD_1B});
      send_reply(CMD_UPLOAD_2B, 16'h1234, 8'h01, 32'hAAAA_AAAA); // wrong command, resend
      send_reply(CMD_UPLOAD_1B, 16'h1234, 8'h01, 32'hFFFF_FF81);
      send_read(16'hABCD, 8'h7F, SIZE_2B);
      send_reply(CMD_UPLOAD_2B, 16'hABCD, 8'h7E, 32'h0);   // wrong subindex, resend
      send_reply(CMD_UPLOAD_2B, 16'hABCD, 8'h7F, 32'h8765_4321);
      send_read(16'hFFFF, 8'hFF, SIZE_4B);
      send_reply(CMD_UPLOAD_4B, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
      send_read(16'h0000, 8'h00, SIZE_4B);
      send_reply(CMD_UPLOAD_1B, 16'h0000, 8'h00, 32'h0123_4567);
      send_read(16'h6040, 8'h00, SIZE_2B);
      send_reply(CMD_ABORT, 16'h9999, 8'h55, 32'h0602_0000); // abort ignores the address
      send_read(16'h1018, 8'h01, SIZE_1B);
      repeat (3) send_tick();                               // timeout, resend
      repeat (3) send_tick();                               // attempts used up, read fails

      // zero retry count: a read fails without a frame
      configure(7'd5, 16'd3, 4'd0);
      send_read(16'h1000, 8'h00, SIZE_4B);
      send_tick();

      // random part, one register setting per phase, extremes first
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: configure(7'd127, 16'd1, 4'd15);
            1: configure(7'd1, 16'd65535, 4'd0);
            2: configure(7'd64, 16'd5, 4'd1);
            default: configure(7'($urandom_range(1, 127)),
                               ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                           : 16'($urandom_range(1, 8)),
                               4'($urandom_range(0, 15)));
         endcase
         sender_steady = ($urandom_range(0, 3) == 0);
         // one long hold-off on the result side while items keep coming
         if (phase == 2) hold_armed = 1'b1;
         goal = items_sent + 215;
         while (items_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
               send_write(16'($urandom), 8'($urandom), size_type'($urandom_range(0, 3)),
                          $urandom);
            end else if (pick < 22) begin
               noise_item();
            end else begin
               read_sequence();
            end
         end
      end

      // wait out the remaining results, bounded
      req_valid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (awaited != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (mismatches == 0 && awaited == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // result side: random stalls, runs of steady ready, one long hold-off
   initial begin : result_sink
      int unsigned span;
      bit held;
      held = 1'b0;
      forever begin
         if (hold_armed && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            span = random_gap();
            if (span != 0) begin
               rsp_ready <= 1'b0;
               repeat (span) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         span = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
         repeat (span) @(posedge clock);
      end
   end

   // hard limit on run length
   initial begin : watchdog
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
